>>> rtl/mbc1d_pkg.sv
// Shared types and constants for the MBC1 memory map decoder.
package mbc1d_pkg;

  localparam int ROM_ADDR_BITS = 22;
  localparam int OFF_W         = 22;
  localparam int BANK_W        = 7;
  localparam int PHYS_W        = BANK_W + 14;
  localparam int LIM_W         = (ROM_ADDR_BITS >= 23) ? ROM_ADDR_BITS + 2 : 24;

  localparam logic [15:0] ADDR_BOOT_END = 16'h0100;
  localparam logic [15:0] ADDR_BANKED   = 16'h4000;
  localparam logic [15:0] ADDR_VRAM     = 16'h8000;
  localparam logic [15:0] ADDR_XRAM     = 16'hA000;
  localparam logic [15:0] ADDR_WRAM     = 16'hC000;
  localparam logic [15:0] ADDR_ECHO     = 16'hE000;
  localparam logic [15:0] ADDR_OAM      = 16'hFE00;
  localparam logic [15:0] ADDR_OAM_END  = 16'hFEA0;
  localparam logic [15:0] ADDR_IO       = 16'hFF00;
  localparam logic [15:0] ADDR_HRAM     = 16'hFF80;
  localparam logic [15:0] ADDR_IE       = 16'hFFFF;

  localparam logic [3:0]  RAM_EN_KEY    = 4'hA;
  localparam logic [8:0]  ROM_SIZE_RST  = 9'd2;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_OVERLAY = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_MBC1      = 2'd0,
    CFG_ROM_SIZE  = 2'd1,
    CFG_XRAM_SIZE = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MW_RAM_EN   = 2'd0,
    MW_BANK_LO  = 2'd1,
    MW_BANK_HI  = 2'd2,
    MW_MODE     = 2'd3
  } mapper_reg_e;

  typedef enum logic [3:0] {
    RG_BOOT = 4'd0,
    RG_ROM  = 4'd1,
    RG_VRAM = 4'd2,
    RG_XRAM = 4'd3,
    RG_WRAM = 4'd4,
    RG_OAM  = 4'd5,
    RG_IO   = 4'd6,
    RG_HRAM = 4'd7,
    RG_FF   = 4'd8,
    RG_00   = 4'd9,
    RG_NONE = 4'd10
  } region_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_t;

  typedef struct packed {
    logic [3:0]       region;
    logic [OFF_W-1:0] offset;
  } out_t;

  typedef struct packed {
    logic        mbc1;
    logic [8:0]  rom_size;
    logic [15:0] xram_bytes;
  } cfg_t;

  typedef struct packed {
    logic [BANK_W-1:0] prg_bank;
    logic              bank_mode;
    logic              ram_en;
    logic [1:0]        sram_bank;
    logic              overlay_on;
  } bank_state_t;

endpackage

>>> rtl/mbc1d_regs.sv
// Configuration registers and MBC1 bank state.
module mbc1d_regs (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  input  logic                  upd_i,
  input  mbc1d_pkg::bank_state_t state_d_i,
  output mbc1d_pkg::cfg_t        cfg_o,
  output mbc1d_pkg::bank_state_t state_o
);

  mbc1d_pkg::cfg_t        cfg_q;
  mbc1d_pkg::bank_state_t state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mbc1       <= 1'b0;
      cfg_q.rom_size   <= mbc1d_pkg::ROM_SIZE_RST;
      cfg_q.xram_bytes <= '0;
    end else if (cfg_we_i) begin
      case (mbc1d_pkg::cfg_idx_e'(cfg_index_i))
        mbc1d_pkg::CFG_MBC1:      cfg_q.mbc1       <= cfg_data_i[0];
        mbc1d_pkg::CFG_ROM_SIZE:  cfg_q.rom_size   <= cfg_data_i[8:0];
        mbc1d_pkg::CFG_XRAM_SIZE: cfg_q.xram_bytes <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.prg_bank   <= '0;
      state_q.bank_mode  <= 1'b0;
      state_q.ram_en     <= 1'b0;
      state_q.sram_bank  <= '0;
      state_q.overlay_on <= 1'b1;
    end else if (upd_i) begin
      state_q <= state_d_i;
    end
  end

  assign cfg_o   = cfg_q;
  assign state_o = state_q;

endmodule

>>> rtl/mbc1d_decode.sv
// Address decode and mapper register update for one bus access.
module mbc1d_decode (
  input  mbc1d_pkg::in_t         item_i,
  input  mbc1d_pkg::cfg_t        cfg_i,
  input  mbc1d_pkg::bank_state_t state_i,
  output mbc1d_pkg::out_t        res_o,
  output mbc1d_pkg::bank_state_t state_d_o
);

  logic [15:0]                    a;
  logic [7:0]                     d;
  logic                           is_read;
  logic [mbc1d_pkg::BANK_W-1:0]   bank;
  logic [mbc1d_pkg::PHYS_W-1:0]   phys;
  logic [mbc1d_pkg::LIM_W-1:0]    lim_size;
  logic [mbc1d_pkg::LIM_W-1:0]    lim_cap;
  logic [mbc1d_pkg::LIM_W-1:0]    lim;
  logic                           rom_ok;
  logic                           xram_ok;

  assign a       = item_i.address;
  assign d       = item_i.write_data;
  assign is_read = (mbc1d_pkg::op_e'(item_i.operation) == mbc1d_pkg::OP_READ);

  // zero in the low five bits selects the next bank up
  always_comb begin
    bank[6:5] = state_i.bank_mode ? 2'b00 : state_i.prg_bank[6:5];
    bank[4:0] = (state_i.prg_bank[4:0] == 5'd0) ? 5'd1 : state_i.prg_bank[4:0];
  end

  always_comb begin
    if (a < mbc1d_pkg::ADDR_BANKED) begin
      phys = mbc1d_pkg::PHYS_W'(a[13:0]);
    end else if (cfg_i.mbc1) begin
      phys = {bank, a[13:0]};
    end else begin
      phys = mbc1d_pkg::PHYS_W'(a[14:0]);
    end
  end

  assign lim_size = {(mbc1d_pkg::LIM_W - 23)'(0), cfg_i.rom_size, 14'd0};
  assign lim_cap  = mbc1d_pkg::LIM_W'(1) << mbc1d_pkg::ROM_ADDR_BITS;
  assign lim      = (lim_size > lim_cap) ? lim_cap : lim_size;
  assign rom_ok   = mbc1d_pkg::LIM_W'(phys) < lim;
  assign xram_ok  = {3'd0, a[12:0]} < cfg_i.xram_bytes;

  always_comb begin
    res_o.region = mbc1d_pkg::RG_NONE;
    res_o.offset = '0;
    state_d_o    = state_i;
    case (mbc1d_pkg::op_e'(item_i.operation))
      mbc1d_pkg::OP_READ, mbc1d_pkg::OP_WRITE: begin
        if (a < mbc1d_pkg::ADDR_VRAM) begin
          if (is_read) begin
            if (state_i.overlay_on && a < mbc1d_pkg::ADDR_BOOT_END) begin
              res_o.region = mbc1d_pkg::RG_BOOT;
              res_o.offset = mbc1d_pkg::OFF_W'(a[7:0]);
            end else if (rom_ok) begin
              res_o.region = mbc1d_pkg::RG_ROM;
              res_o.offset = mbc1d_pkg::OFF_W'(phys);
            end else begin
              res_o.region = mbc1d_pkg::RG_FF;
            end
          end else if (cfg_i.mbc1) begin
            case (mbc1d_pkg::mapper_reg_e'(a[14:13]))
              mbc1d_pkg::MW_RAM_EN:  state_d_o.ram_en = (d[3:0] == mbc1d_pkg::RAM_EN_KEY);
              mbc1d_pkg::MW_BANK_LO: state_d_o.prg_bank[4:0] = d[4:0];
              mbc1d_pkg::MW_BANK_HI: begin
                if (!state_i.bank_mode) begin
                  state_d_o.prg_bank[6:5] = d[1:0];
                end else begin
                  state_d_o.sram_bank = d[1:0];
                end
              end
              mbc1d_pkg::MW_MODE:    state_d_o.bank_mode = d[0];
              default: ;
            endcase
          end
        end else if (a < mbc1d_pkg::ADDR_XRAM) begin
          res_o.region = mbc1d_pkg::RG_VRAM;
          res_o.offset = mbc1d_pkg::OFF_W'(a - mbc1d_pkg::ADDR_VRAM);
        end else if (a < mbc1d_pkg::ADDR_WRAM) begin
          if (xram_ok) begin
            res_o.region = mbc1d_pkg::RG_XRAM;
            res_o.offset = mbc1d_pkg::OFF_W'(a - mbc1d_pkg::ADDR_XRAM);
          end else if (is_read) begin
            res_o.region = mbc1d_pkg::RG_00;
          end
        end else if (a < mbc1d_pkg::ADDR_ECHO) begin
          res_o.region = mbc1d_pkg::RG_WRAM;
          res_o.offset = mbc1d_pkg::OFF_W'(a - mbc1d_pkg::ADDR_WRAM);
        end else if (a >= mbc1d_pkg::ADDR_OAM && a < mbc1d_pkg::ADDR_OAM_END) begin
          res_o.region = mbc1d_pkg::RG_OAM;
          res_o.offset = mbc1d_pkg::OFF_W'(a - mbc1d_pkg::ADDR_OAM);
        end else if ((a >= mbc1d_pkg::ADDR_IO && a < mbc1d_pkg::ADDR_HRAM) ||
                     a == mbc1d_pkg::ADDR_IE) begin
          res_o.region = mbc1d_pkg::RG_IO;
          res_o.offset = mbc1d_pkg::OFF_W'(a[7:0]);
        end else if (a >= mbc1d_pkg::ADDR_HRAM) begin
          res_o.region = mbc1d_pkg::RG_HRAM;
          res_o.offset = mbc1d_pkg::OFF_W'(a - mbc1d_pkg::ADDR_HRAM);
        end else if (is_read) begin
          res_o.region = mbc1d_pkg::RG_FF;
        end
      end
      mbc1d_pkg::OP_OVERLAY: begin
        if (d[0]) begin
          state_d_o.overlay_on = 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/handheld_memory_map_mbc1_decoder.sv
// Top level of the MBC1 cartridge memory map decoder.
//
// One bus access (read, write, boot overlay control write or no-op) enters
// on the in channel per item; one result (region, offset) leaves on the out
// channel for every item. Both channels use valid/ready.
// Items pass an input register, then one pass of decode logic that also
// updates the bank registers, then a result register. out_valid_o rises
// when the item moves from the input register into the result register;
// when the receiver is ready one item per cycle is sustained, set by the
// single decode pass between the two registers. Bank state is updated as an
// item moves into the result register, so the next item already sees it.
// When the receiver stalls, the result holds and the input register still
// takes one more item; after that in_ready_o drops until the result is taken.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect at
// once and are meant for idle periods; an index beyond the list is ignored.
// Reset clears both pipeline valid flags, the bank registers and mode, sets
// the boot overlay on and loads plain ROM of two banks with no external RAM.
module handheld_memory_map_mbc1_decoder (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [15:0]      cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mbc1d_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mbc1d_pkg::out_t  out_data_o
);

  logic                   s1_valid_q;
  mbc1d_pkg::in_t         s1_item_q;
  logic                   out_valid_q;
  mbc1d_pkg::out_t        out_data_q;
  logic                   advance;
  mbc1d_pkg::cfg_t        cfg;
  mbc1d_pkg::bank_state_t state;
  mbc1d_pkg::bank_state_t state_d;
  mbc1d_pkg::out_t        res_d;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  mbc1d_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .upd_i      (advance),
    .state_d_i  (state_d),
    .cfg_o      (cfg),
    .state_o    (state)
  );

  mbc1d_decode u_decode (
    .item_i   (s1_item_q),
    .cfg_i    (cfg),
    .state_i  (state),
    .res_o    (res_d),
    .state_d_o(state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/mbc1d_checker.sv
// Port-level checks for the MBC1 memory map decoder, bound to the top level.
module mbc1d_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input mbc1d_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_region_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.region <= mbc1d_pkg::RG_NONE)
    else $error("region code out of range");

  a_fixed_zero_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.region == mbc1d_pkg::RG_FF ||
                    out_data_o.region == mbc1d_pkg::RG_00 ||
                    out_data_o.region == mbc1d_pkg::RG_NONE)
    |-> out_data_o.offset == '0)
    else $error("nonzero offset for storeless region");

  a_small_regions: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.region != mbc1d_pkg::RG_OAM  || out_data_o.offset < 22'h0A0) &&
      (out_data_o.region != mbc1d_pkg::RG_HRAM || out_data_o.offset < 22'h07F) &&
      (out_data_o.region != mbc1d_pkg::RG_BOOT || out_data_o.offset < 22'h100) &&
      (out_data_o.region != mbc1d_pkg::RG_VRAM || out_data_o.offset < 22'h2000))
    else $error("offset beyond region size");

endmodule

bind handheld_memory_map_mbc1_decoder mbc1d_checker u_mbc1d_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

>>> tb/handheld_memory_map_mbc1_decoder_test.sv
// Self-checking MBC1 memory map decoder bench: directed and random accesses with a predictor.
`timescale 1ns / 1ps

module handheld_memory_map_mbc1_decoder_test;

  localparam int LONG_HOLD = 200;

  class mbc1_map_model;
    logic            mbc1_on;
    logic [8:0]      rom_size;
    logic [15:0]     xram_bytes;
    logic [6:0]      prg_bank;
    logic            bank_mode;
    logic            ram_en;
    logic [1:0]      sram_bank;
    logic            overlay_on;
    mbc1d_pkg::out_t pending[$];
    int              errors;

    function new();
      mbc1_on    = 1'b0;
      rom_size   = mbc1d_pkg::ROM_SIZE_RST;
      xram_bytes = '0;
      prg_bank   = '0;
      bank_mode  = 1'b0;
      ram_en     = 1'b0;
      sram_bank  = '0;
      overlay_on = 1'b1;
      errors     = 0;
    endfunction

    function void set_reg(mbc1d_pkg::cfg_idx_e idx, logic [15:0] value);
      case (idx)
        mbc1d_pkg::CFG_MBC1:      mbc1_on = value[0];
        mbc1d_pkg::CFG_ROM_SIZE:  rom_size = value[8:0];
        mbc1d_pkg::CFG_XRAM_SIZE: xram_bytes = value;
        default: ;
      endcase
    endfunction

    function mbc1d_pkg::out_t rom_lookup(int unsigned phys);
      int unsigned     limit;
      mbc1d_pkg::out_t r;
      limit = rom_size * 32'h4000;
      if (limit > (32'd1 << mbc1d_pkg::ROM_ADDR_BITS)) begin
        limit = 32'd1 << mbc1d_pkg::ROM_ADDR_BITS;
      end
      r.region = (phys < limit) ? mbc1d_pkg::RG_ROM : mbc1d_pkg::RG_FF;
      r.offset = (phys < limit) ? phys[mbc1d_pkg::OFF_W-1:0] : '0;
      return r;
    endfunction

    // 0x8000 and up; reads and writes differ only where nothing answers
    function mbc1d_pkg::out_t map_data_area(logic [15:0] a, bit is_read);
      mbc1d_pkg::out_t r;
      r.region = is_read ? mbc1d_pkg::RG_FF : mbc1d_pkg::RG_NONE;
      r.offset = '0;
      if (a < mbc1d_pkg::ADDR_XRAM) begin
        r.region = mbc1d_pkg::RG_VRAM;
        r.offset = mbc1d_pkg::OFF_W'(a - mbc1d_pkg::ADDR_VRAM);
      end else if (a < mbc1d_pkg::ADDR_WRAM) begin
        if (a - mbc1d_pkg::ADDR_XRAM < xram_bytes) begin
          r.region = mbc1d_pkg::RG_XRAM;
          r.offset = mbc1d_pkg::OFF_W'(a - mbc1d_pkg::ADDR_XRAM);
        end else if (is_read) begin
          r.region = mbc1d_pkg::RG_00;
        end
      end else if (a < mbc1d_pkg::ADDR_ECHO) begin
        r.region = mbc1d_pkg::RG_WRAM;
        r.offset = mbc1d_pkg::OFF_W'(a - mbc1d_pkg::ADDR_WRAM);
      end else if (a >= mbc1d_pkg::ADDR_OAM && a < mbc1d_pkg::ADDR_OAM_END) begin
        r.region = mbc1d_pkg::RG_OAM;
        r.offset = mbc1d_pkg::OFF_W'(a - mbc1d_pkg::ADDR_OAM);
      end else if ((a >= mbc1d_pkg::ADDR_IO && a < mbc1d_pkg::ADDR_HRAM) ||
                   a == mbc1d_pkg::ADDR_IE) begin
        r.region = mbc1d_pkg::RG_IO;
        r.offset = mbc1d_pkg::OFF_W'(a[7:0]);
      end else if (a >= mbc1d_pkg::ADDR_HRAM) begin
        r.region = mbc1d_pkg::RG_HRAM;
        r.offset = mbc1d_pkg::OFF_W'(a - mbc1d_pkg::ADDR_HRAM);
      end
      return r;
    endfunction

    function void note_access(mbc1d_pkg::in_t item);
      mbc1d_pkg::out_t r;
      int unsigned     bank;
      logic [15:0]     a;
      logic [7:0]      d;
      a = item.address;
      d = item.write_data;
      r.region = mbc1d_pkg::RG_NONE;
      r.offset = '0;
      case (mbc1d_pkg::op_e'(item.operation))
        mbc1d_pkg::OP_READ: begin
          if (a < mbc1d_pkg::ADDR_BANKED) begin
            if (overlay_on && a < mbc1d_pkg::ADDR_BOOT_END) begin
              r.region = mbc1d_pkg::RG_BOOT;
              r.offset = mbc1d_pkg::OFF_W'(a);
            end else begin
              r = rom_lookup(32'(a));
            end
          end else if (a < mbc1d_pkg::ADDR_VRAM) begin
            if (mbc1_on) begin
              bank = bank_mode ? 32'(prg_bank[4:0]) : 32'(prg_bank);
              if (bank[4:0] == 5'd0) bank++;
              r = rom_lookup(32'(a - mbc1d_pkg::ADDR_BANKED) + bank * 32'h4000);
            end else begin
              r = rom_lookup(32'(a));
            end
          end else begin
            r = map_data_area(a, 1'b1);
          end
        end
        mbc1d_pkg::OP_WRITE: begin
          if (a >= mbc1d_pkg::ADDR_VRAM) begin
            r = map_data_area(a, 1'b0);
          end else if (mbc1_on) begin
            case (mbc1d_pkg::mapper_reg_e'(a[14:13]))
              mbc1d_pkg::MW_RAM_EN:  ram_en = (d[3:0] == mbc1d_pkg::RAM_EN_KEY);
              mbc1d_pkg::MW_BANK_LO: prg_bank[4:0] = d[4:0];
              mbc1d_pkg::MW_BANK_HI: begin
                if (bank_mode) sram_bank = d[1:0];
                else prg_bank[6:5] = d[1:0];
              end
              mbc1d_pkg::MW_MODE:    bank_mode = d[0];
              default: ;
            endcase
          end
        end
        mbc1d_pkg::OP_OVERLAY: begin
          if (d[0]) overlay_on = 1'b0;
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(mbc1d_pkg::out_t got);
      mbc1d_pkg::out_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with no access pending, region %0d offset %h",
                 $time, got.region, got.offset);
        return;
      end
      want = pending.pop_front();
      if (got.region !== want.region) begin
        errors++;
        $display("%0t: region expected %0d got %0d", $time, want.region, got.region);
      end
      if (got.offset !== want.offset) begin
        errors++;
        $display("%0t: offset expected %h got %h", $time, want.offset, got.offset);
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_we = 1'b0;
  logic [1:0]      cfg_index = '0;
  logic [15:0]     cfg_data = '0;
  logic            access_valid = 1'b0;
  mbc1d_pkg::in_t  access = '0;
  logic            in_ready;
  logic            result_valid;
  logic            result_ready = 1'b1;
  mbc1d_pkg::out_t result;
  bit              steady = 1'b0;
  bit              hold_req = 1'b0;

  mbc1_map_model board;

  handheld_memory_map_mbc1_decoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (access_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (access),
    .out_valid_o (result_valid),
    .out_ready_i (result_ready),
    .out_data_o  (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (result_valid && result_ready) board.check_result(result);
      if (access_valid && in_ready) board.note_access(access);
    end
  end

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (steady || pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic mbc1d_pkg::in_t make_item(mbc1d_pkg::op_e op, logic [15:0] a,
                                                logic [7:0] d);
    mbc1d_pkg::in_t item;
    item.operation  = op;
    item.address    = a;
    item.write_data = d;
    return item;
  endfunction

  function automatic mbc1d_pkg::in_t random_access();
    mbc1d_pkg::in_t item;
    int             pick;
    item.write_data = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 50) item.operation = mbc1d_pkg::OP_READ;
    else if (pick < 88) item.operation = mbc1d_pkg::OP_WRITE;
    else if (pick < 94) item.operation = mbc1d_pkg::OP_OVERLAY;
    else item.operation = mbc1d_pkg::OP_NOP;
    case ($urandom_range(0, 9))
      0, 1, 2: item.address = 16'($urandom_range(0, 16'h7FFF));
      3, 4:    item.address = 16'($urandom_range(16'h4000, 16'h7FFF));
      5:       item.address = 16'($urandom_range(16'hA000, 16'hBFFF));
      6:       item.address = 16'($urandom_range(16'hFE00, 16'hFFFF));
      7: begin
        case ($urandom_range(0, 10))
          0:       item.address = mbc1d_pkg::ADDR_BOOT_END;
          1:       item.address = mbc1d_pkg::ADDR_BANKED;
          2:       item.address = mbc1d_pkg::ADDR_VRAM;
          3:       item.address = mbc1d_pkg::ADDR_XRAM;
          4:       item.address = mbc1d_pkg::ADDR_WRAM;
          5:       item.address = mbc1d_pkg::ADDR_ECHO;
          6:       item.address = mbc1d_pkg::ADDR_OAM;
          7:       item.address = mbc1d_pkg::ADDR_OAM_END;
          8:       item.address = mbc1d_pkg::ADDR_IO;
          9:       item.address = mbc1d_pkg::ADDR_HRAM;
          default: item.address = 16'h0000;
        endcase
        // land on either side of the boundary
        item.address = item.address - 16'($urandom_range(0, 1));
      end
      default: item.address = 16'($urandom);
    endcase
    if ($urandom_range(0, 3) == 0) item.write_data[3:0] = mbc1d_pkg::RAM_EN_KEY;
    return item;
  endfunction

  task automatic send_access(mbc1d_pkg::in_t item);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      access_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    access_valid <= 1'b1;
    access <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic random_run(int count);
    for (int i = 0; i < count; i++) send_access(random_access());
  endtask

  task automatic drain();
    access_valid <= 1'b0;
    do @(posedge clk); while (board.pending.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(mbc1d_pkg::cfg_idx_e idx, logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, value);
  endtask

  task automatic set_config(logic mbc1, logic [8:0] banks, logic [15:0] xram);
    write_reg(mbc1d_pkg::CFG_MBC1, {15'd0, mbc1});
    write_reg(mbc1d_pkg::CFG_ROM_SIZE, {7'd0, banks});
    write_reg(mbc1d_pkg::CFG_XRAM_SIZE, xram);
    write_reg(mbc1d_pkg::CFG_UNUSED, 16'($urandom));
  endtask

  initial begin : result_sink
    int stall;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        result_ready <= 1'b1;
      end else begin
        stall = idle_len();
        if (stall == 0) begin
          result_ready <= 1'b1;
        end else begin
          result_ready <= 1'b0;
          repeat (stall) @(posedge clk);
          result_ready <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    board = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset setup: plain ROM, two banks, no external RAM, boot overlay on
    send_access(make_item(mbc1d_pkg::OP_READ, 16'h0000, 8'h00));
    send_access(make_item(mbc1d_pkg::OP_READ, 16'h00FF, 8'h00));
    send_access(make_item(mbc1d_pkg::OP_READ, 16'h0100, 8'h00));
    send_access(make_item(mbc1d_pkg::OP_READ, 16'h7FFF, 8'h00));
    send_access(make_item(mbc1d_pkg::OP_READ, 16'h9FFF, 8'h00));
    send_access(make_item(mbc1d_pkg::OP_READ, 16'hA000, 8'h00));
    send_access(make_item(mbc1d_pkg::OP_WRITE, 16'hA000, 8'h5A));
    send_access(make_item(mbc1d_pkg::OP_READ, 16'hDFFF, 8'h00));
    send_access(make_item(mbc1d_pkg::OP_READ, 16'hE000, 8'h00));
    send_access(make_item(mbc1d_pkg::OP_READ, 16'hFE9F, 8'h00));
    send_access(make_item(mbc1d_pkg::OP_READ, 16'hFEA0, 8'h00));
    send_access(make_item(mbc1d_pkg::OP_READ, 16'hFF7F, 8'h00));
    send_access(make_item(mbc1d_pkg::OP_READ, 16'hFF80, 8'h00));
    send_access(make_item(mbc1d_pkg::OP_READ, 16'hFFFF, 8'h00));
    send_access(make_item(mbc1d_pkg::OP_NOP, 16'h1234, 8'hFF));
    send_access(make_item(mbc1d_pkg::OP_OVERLAY, 16'hFF50, 8'hFE));
    random_run(200);

    drain();
    set_config(1'b1, 9'd256, 16'd32768);
    send_access(make_item(mbc1d_pkg::OP_WRITE, 16'h2000, 8'h00));
    send_access(make_item(mbc1d_pkg::OP_READ, 16'h4000, 8'h00));
    send_access(make_item(mbc1d_pkg::OP_WRITE, 16'h5FFF, 8'h7F));
    send_access(make_item(mbc1d_pkg::OP_WRITE, 16'h3FFF, 8'h1F));
    send_access(make_item(mbc1d_pkg::OP_READ, 16'h7FFF, 8'h00));
    send_access(make_item(mbc1d_pkg::OP_WRITE, 16'h6000, 8'h01));
    send_access(make_item(mbc1d_pkg::OP_READ, 16'h4000, 8'h00));
    send_access(make_item(mbc1d_pkg::OP_OVERLAY, 16'hFF50, 8'hFF));
    send_access(make_item(mbc1d_pkg::OP_READ, 16'h00FF, 8'h00));

    for (int p = 0; p < 7; p++) begin
      drain();
      case (p)
        0: set_config(1'b1, 9'd256, 16'd32768);
        1: set_config(1'b1, 9'd2, 16'd0);
        2: set_config(1'b0, 9'd256, 16'd8192);
        3: set_config(1'b1, 9'($urandom_range(3, 255)), 16'($urandom_range(0, 32768)));
        4: set_config(1'b1, 9'd64, 16'd1);
        5: set_config(1'b0, 9'd2, 16'd32768);
        default: set_config(1'b1, 9'($urandom_range(2, 256)), 16'd8191);
      endcase
      steady = (p == 3);
      if (p == 4) begin
        random_run(100);
        hold_req = 1'b1;
        random_run(150);
      end else begin
        random_run(250);
      end
    end
    steady = 1'b0;

    drain();
    if (board.errors == 0) begin
      $display("handheld_memory_map_mbc1_decoder_test OK");
    end else begin
      $display("handheld_memory_map_mbc1_decoder_test NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #6ms;
    $display("handheld_memory_map_mbc1_decoder_test NOT OK");
    $finish;
  end

endmodule
